@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, ignored while reset is high
`define ASSERT_CLKD(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Concurrent check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

@@ rtl/ratf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratf_pkg
// Types and constants of the read adapter trim filter.
// ----------------------------------------------------------------------------
package ratf_pkg;

  localparam int MAX_READ_LEN    = 1024;
  localparam int MAX_ADAPTER_LEN = 8;

  localparam int CHAR_W    = 8;
  localparam int POS_W     = $clog2(MAX_READ_LEN + 2);
  localparam int START_W   = $clog2(MAX_READ_LEN);
  localparam int LEN_W     = 4;
  localparam int KEPT_W    = 11;
  localparam int COUNT_W   = 32;
  localparam int MINLEN_W  = 11;
  localparam int ADAPTER_W = 64;
  localparam int CFG_IDX_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_N    = 8'h4E;
  localparam logic [POS_W-1:0]  NO_N_SEEN = '1;

  localparam logic [CFG_IDX_W-1:0] REG_ADAPTER_CHARS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPTER_LENGTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_UNTRIMMED = 8'd3;

  typedef enum logic [1:0] {
    VERDICT_DROP = 2'd0,
    VERDICT_TRIM = 2'd1,
    VERDICT_KEEP = 2'd2,
    VERDICT_LONG = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [COUNT_W-1:0] trimmed_reads;
    logic [COUNT_W-1:0] total_reads;
    logic [KEPT_W-1:0]  kept_length;
    verdict_t           verdict;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ rtl/read_adapter_trim_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_adapter_trim_filter
// Exact-match adapter trimming and length filter for sequencing reads.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sequence character per word, s_tlast on the final one.
//   m_* carries one verdict word per read, issued after its last character.
//   cfg_* writes adapter characters, adapter length, minimum length and the
//   keep flag; it is always ready and must only be used between reads.
// Latency: the verdict word is valid on m_* the cycle after the last
//   character is accepted, unless an earlier verdict still waits in the buffer.
// Throughput: one character per cycle while s_tready is high; the window
//   compare against the adapter and the verdict logic sit between the state
//   registers and a two-entry output buffer.
// Stall: while m_tready is low up to two verdicts are held; s_tready drops
//   only when both entries are full, so characters keep streaming until a
//   second verdict waits.
// Reset: rst (synchronous) clears read state, totals and the output buffer
//   and loads the register defaults (adapter length 6, minimum length 18).
// ----------------------------------------------------------------------------
module read_adapter_trim_filter
  import ratf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [CHAR_W-1:0]    s_tdata,   // [7:0] base_char
  input  logic                 s_tlast,   // last_base
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // verdict, kept_length, total_reads, trimmed_reads
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADAPTER_W-1:0] cfg_data
);

  localparam int SEL_W = $clog2(MAX_ADAPTER_LEN + 1);

  logic [ADAPTER_W-1:0] adapter_chars;
  logic [LEN_W-1:0]     adapter_length;
  logic [MINLEN_W-1:0]  min_length;
  logic                 keep_untrimmed;

  logic [CHAR_W-1:0]  recent_chars [MAX_ADAPTER_LEN];
  logic [POS_W-1:0]   char_position;
  logic               match_seen;
  logic [START_W-1:0] match_start;
  logic [POS_W-1:0]   first_n_position;
  logic [COUNT_W-1:0] read_count;
  logic [COUNT_W-1:0] trimmed_count;

  logic               main_valid;
  result_t            main_data;
  logic               skid_valid;
  result_t            skid_data;

  logic [CHAR_W-1:0]  window [MAX_ADAPTER_LEN];
  logic               match_at [MAX_ADAPTER_LEN + 1];
  logic [LEN_W-1:0]   len_eff;
  logic               hit;
  logic [POS_W-1:0]   char_position_next;
  logic               match_seen_next;
  logic [START_W-1:0] match_start_next;
  logic [POS_W-1:0]   first_n_position_next;
  logic [COUNT_W-1:0] read_count_next;
  logic [COUNT_W-1:0] trimmed_count_next;
  result_t            result;
  logic               accept;
  logic               push;
  logic               pop;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign push      = accept && s_tlast;
  assign pop       = main_valid && m_tready;
  assign m_tvalid  = main_valid;
  assign m_tdata   = OUT_W'(main_data);

  // window after shifting in the new character, newest first
  always_comb begin
    window[0] = s_tdata;
    for (int i = 1; i < MAX_ADAPTER_LEN; i++) begin
      window[i] = recent_chars[i-1];
    end
  end

  always_comb begin
    match_at[0] = 1'b1;
    for (int l = 1; l <= MAX_ADAPTER_LEN; l++) begin
      match_at[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (window[l-1-k] != adapter_chars[CHAR_W*k +: CHAR_W]) begin
          match_at[l] = 1'b0;
        end
      end
    end
  end

  assign len_eff = (adapter_length > LEN_W'(MAX_ADAPTER_LEN)) ?
                   LEN_W'(MAX_ADAPTER_LEN) : adapter_length;

  assign hit = ({1'b0, char_position} + (POS_W+1)'(1) >= (POS_W+1)'(len_eff)) &&
               match_at[len_eff[SEL_W-1:0]];

  always_comb begin
    char_position_next    = char_position;
    match_seen_next       = match_seen;
    match_start_next      = match_start;
    first_n_position_next = first_n_position;
    if (char_position < POS_W'(MAX_READ_LEN)) begin
      if (s_tdata == CHAR_N && first_n_position == NO_N_SEEN) begin
        first_n_position_next = char_position;
      end
      if (!match_seen && hit) begin
        match_seen_next = 1'b1;
        // an empty adapter matches at the read start
        if (len_eff == '0) begin
          match_start_next = '0;
        end else begin
          match_start_next = START_W'(char_position + POS_W'(1) - POS_W'(len_eff));
        end
      end
      char_position_next = char_position + POS_W'(1);
    end else begin
      char_position_next = POS_W'(MAX_READ_LEN + 1);
    end
  end

  always_comb begin
    result.verdict     = VERDICT_DROP;
    result.kept_length = '0;
    if (char_position_next > POS_W'(MAX_READ_LEN)) begin
      result.verdict = VERDICT_LONG;
    end else if (match_seen_next) begin
      if ({1'b0, match_start_next} >= MINLEN_W'(min_length) &&
          first_n_position_next >= POS_W'(match_start_next)) begin
        result.verdict     = VERDICT_TRIM;
        result.kept_length = KEPT_W'(match_start_next);
      end
    end else if (keep_untrimmed) begin
      result.verdict     = VERDICT_KEEP;
      result.kept_length = KEPT_W'(char_position_next);
    end
    read_count_next      = read_count + COUNT_W'(1);
    trimmed_count_next   = trimmed_count +
                           COUNT_W'(result.verdict == VERDICT_TRIM);
    result.total_reads   = read_count_next;
    result.trimmed_reads = trimmed_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adapter_chars  <= '0;
      adapter_length <= LEN_W'(6);
      min_length     <= MINLEN_W'(18);
      keep_untrimmed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ADAPTER_CHARS:  adapter_chars  <= cfg_data;
        REG_ADAPTER_LENGTH: adapter_length <= cfg_data[LEN_W-1:0];
        REG_MIN_LENGTH:     min_length     <= cfg_data[MINLEN_W-1:0];
        REG_KEEP_UNTRIMMED: keep_untrimmed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ADAPTER_LEN; i++) begin
        recent_chars[i] <= '0;
      end
      char_position    <= '0;
      match_seen       <= 1'b0;
      match_start      <= '0;
      first_n_position <= NO_N_SEEN;
      read_count       <= '0;
      trimmed_count    <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        for (int i = 0; i < MAX_ADAPTER_LEN; i++) begin
          recent_chars[i] <= '0;
        end
        char_position    <= '0;
        match_seen       <= 1'b0;
        match_start      <= '0;
        first_n_position <= NO_N_SEEN;
        read_count       <= read_count_next;
        trimmed_count    <= trimmed_count_next;
      end else begin
        for (int i = 0; i < MAX_ADAPTER_LEN; i++) begin
          recent_chars[i] <= window[i];
        end
        char_position    <= char_position_next;
        match_seen       <= match_seen_next;
        match_start      <= match_start_next;
        first_n_position <= first_n_position_next;
      end
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data <= result;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= result;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/ratf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ratf_checker
// Port-level checks of the read adapter trim filter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ratf_checker
  import ratf_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  result_t res;
  assign res = result_t'(m_tdata[RESULT_W-1:0]);

  `ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> !m_tvalid, "verdict word right after reset")
  `ASSERT_CLKD(a_stall_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled verdict word changed")
  `ASSERT_CLKD(a_drop_zero_len, clk, rst, m_tvalid && (res.verdict == VERDICT_DROP || res.verdict == VERDICT_LONG) |-> res.kept_length == '0, "dropped read with nonzero kept length")
  `ASSERT_CLKD(a_len_bound, clk, rst, m_tvalid |-> res.kept_length <= KEPT_W'(MAX_READ_LEN), "kept length above maximum read length")

endmodule

bind read_adapter_trim_filter ratf_checker u_ratf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
